// ===== rtl/core/fbpa_pkg.sv =====
// Shared types, widths and constants of the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int INDEX_SPAN     = 1024;

    localparam int SIZE_W  = 17;
    localparam int COUNT_W = 11;
    localparam int REQ_W   = 32;
    localparam int IDX_W   = 10;
    localparam int BYTE_W  = 27;
    localparam int PROD_W  = COUNT_W + SIZE_W;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 17'd64;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SIZE    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DONE
    } t_state;

    // Control from the sequencer to the accounting unit.
    typedef struct packed {
        logic mul_en;
        logic commit;
    } t_acct_ctl;

    // Accounting view as seen by the result word.
    typedef struct packed {
        logic [COUNT_W-1:0] live_peak;
        logic [BYTE_W-1:0]  byte_total;
        logic [BYTE_W-1:0]  byte_peak;
    } t_acct_view;

endpackage

// ===== rtl/core/fbpa_req_if.sv =====
// Request channel of the allocator: valid/ready plus the request word.
interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [fbpa_pkg::REQ_W-1:0]    request_size;
    logic [fbpa_pkg::IDX_W-1:0]    freed_block;

    modport source (output valid, output operation, output request_size,
                    output freed_block, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input freed_block, output ready);
endinterface

// ===== rtl/core/fbpa_rsp_if.sv =====
// Result channel of the allocator: valid/ready plus the result word.
interface fbpa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [fbpa_pkg::IDX_W-1:0]      block_index;
    logic [fbpa_pkg::COUNT_W-1:0]    live_blocks;
    logic [fbpa_pkg::COUNT_W-1:0]    peak_blocks;
    logic [fbpa_pkg::BYTE_W-1:0]     bytes_in_use;
    logic [fbpa_pkg::BYTE_W-1:0]     peak_bytes;

    modport source (output valid, output status, output block_index,
                    output live_blocks, output peak_blocks, output bytes_in_use,
                    output peak_bytes, input ready);
    modport sink   (input valid, input status, input block_index,
                    input live_blocks, input peak_blocks, input bytes_in_use,
                    input peak_bytes, output ready);
endinterface

// ===== rtl/core/fbpa_stack_mem.sv =====
// Freed-block stack storage: one write port, one read port, registered read.
module fbpa_stack_mem #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    i_waddr,
    input  logic [fbpa_pkg::IDX_W-1:0]       i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    i_raddr,
    output logic [fbpa_pkg::IDX_W-1:0]       o_rdata
);

    logic [fbpa_pkg::IDX_W-1:0] r_mem [MAX_BLOCKS];
    logic [fbpa_pkg::IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fbpa_acct.sv =====
// Byte accounting: live count times block size, saturation and peak tracking.
module fbpa_acct (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fbpa_pkg::t_acct_ctl             i_ctl,
    input  logic [fbpa_pkg::COUNT_W-1:0]    i_live,
    input  logic [fbpa_pkg::SIZE_W-1:0]     i_block_size,
    output fbpa_pkg::t_acct_view            o_view
);

    logic [fbpa_pkg::PROD_W-1:0]  r_prod;
    logic [fbpa_pkg::COUNT_W-1:0] r_live_peak;
    logic [fbpa_pkg::BYTE_W-1:0]  r_byte_total;
    logic [fbpa_pkg::BYTE_W-1:0]  r_byte_peak;
    logic [fbpa_pkg::COUNT_W-1:0] n_live_peak;
    logic [fbpa_pkg::BYTE_W-1:0]  n_byte_total;
    logic [fbpa_pkg::BYTE_W-1:0]  n_byte_peak;

    // Product register: one 11x17 multiply per request.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= {{fbpa_pkg::SIZE_W{1'b0}}, i_live}
                    * {{fbpa_pkg::COUNT_W{1'b0}}, i_block_size};
        end
    end

    always_comb begin
        // Saturate at the top of the byte range.
        n_byte_total = r_prod[fbpa_pkg::PROD_W-1]
                     ? {fbpa_pkg::BYTE_W{1'b1}} : r_prod[fbpa_pkg::BYTE_W-1:0];
        n_live_peak  = (i_live > r_live_peak) ? i_live : r_live_peak;
        n_byte_peak  = (n_byte_total > r_byte_peak) ? n_byte_total : r_byte_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_peak  <= '0;
            r_byte_total <= '0;
            r_byte_peak  <= '0;
        end else if (i_ctl.commit) begin
            r_live_peak  <= n_live_peak;
            r_byte_total <= n_byte_total;
            r_byte_peak  <= n_byte_peak;
        end
    end

    always_comb begin
        if (i_ctl.commit) begin
            o_view.live_peak  = n_live_peak;
            o_view.byte_total = n_byte_total;
            o_view.byte_peak  = n_byte_peak;
        end else begin
            o_view.live_peak  = r_live_peak;
            o_view.byte_total = r_byte_total;
            o_view.byte_peak  = r_byte_peak;
        end
    end

endmodule

// ===== rtl/core/fixed_block_pool_allocator_unit.sv =====
// Top level of the fixed block pool allocator: sequencer, counters, result register.
//
// Fixed-size block pool with a LIFO free list. Each request word (allocate or
// free) yields exactly one result word. An allocate whose request_size equals
// block_size takes the most recently freed block from the freed-block stack,
// or, if the stack is empty, the lowest block not yet handed out; otherwise it
// is rejected as a size mismatch (checked first) or an empty pool. A free is
// rejected when the index lies outside the pool (block_count capped at
// MAX_BLOCKS and at 1024), when no block is live, or when the stack is full.
// Rejected requests change no state and report block_index 0. The accepting
// cycle decides the request and issues the stack access. The next cycle reads
// back the stack and multiplies live count by block size. The final step then
// commits the counters and loads the result register in the same edge, once
// that register is empty or being drained. One request is in flight at a time:
// the block takes no new request until the last one has left its final step.
// A new request is accepted while the previous result still waits in the
// result register; it then holds in its final step until that register frees.
// Write block_size (index 0) and block_count (index 1) only while no request is
// pending; reset leaves them at 64 and 1024. The freed-block stack needs no
// clearing after reset.
module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fbpa_req_if.sink                          i_req,
    fbpa_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int DW = $clog2(MAX_BLOCKS + 1);
    localparam int POOL_CAP = (MAX_BLOCKS < fbpa_pkg::INDEX_SPAN)
                            ? MAX_BLOCKS : fbpa_pkg::INDEX_SPAN;

    // Configuration registers.
    logic [fbpa_pkg::SIZE_W-1:0]  r_block_size;
    logic [fbpa_pkg::COUNT_W-1:0] r_block_count;

    // Pool state.
    logic [DW-1:0]                r_depth;
    logic [fbpa_pkg::COUNT_W-1:0] r_fresh;
    logic [fbpa_pkg::COUNT_W-1:0] r_live;

    // Request in flight.
    fbpa_pkg::t_state             r_state;
    fbpa_pkg::t_state             n_state;
    fbpa_pkg::t_status            r_status;
    fbpa_pkg::t_status            n_status;
    logic                         r_from_stack;
    logic [fbpa_pkg::IDX_W-1:0]   r_grant;
    logic [fbpa_pkg::IDX_W-1:0]   n_grant;

    // Result register.
    logic                         r_out_valid;
    fbpa_pkg::t_status            r_out_status;
    logic [fbpa_pkg::IDX_W-1:0]   r_out_index;
    logic [fbpa_pkg::COUNT_W-1:0] r_out_live;
    logic [fbpa_pkg::COUNT_W-1:0] r_out_peak;
    logic [fbpa_pkg::BYTE_W-1:0]  r_out_bytes;
    logic [fbpa_pkg::BYTE_W-1:0]  r_out_peak_bytes;

    logic                         req_ready;
    logic                         in_fire;
    logic                         done_go;
    logic [fbpa_pkg::COUNT_W-1:0] pool_n;
    logic                         size_ok;
    logic                         can_pop;
    logic                         can_fresh;
    logic                         free_bad;
    logic                         do_pop;
    logic                         do_push;
    logic                         do_fresh;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    logic [DW-1:0]                depth_dec;
    logic [fbpa_pkg::IDX_W-1:0]   mem_rdata;
    fbpa_pkg::t_acct_ctl          acct_ctl;
    fbpa_pkg::t_acct_view         acct_view;

    // ---------------------------------------------------------------
    // Configuration writes.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size  <= fbpa_pkg::BLOCK_SIZE_RST;
            r_block_count <= fbpa_pkg::BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_BLOCK_SIZE: begin
                    r_block_size <= i_cfg_data[fbpa_pkg::SIZE_W-1:0];
                end
                fbpa_pkg::CFG_BLOCK_COUNT: begin
                    r_block_count <= i_cfg_data[fbpa_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state and outputs.
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (in_fire) n_state = fbpa_pkg::S_MUL;
            end
            fbpa_pkg::S_MUL: begin
                n_state = fbpa_pkg::S_DONE;
            end
            fbpa_pkg::S_DONE: begin
                if (done_go) n_state = fbpa_pkg::S_IDLE;
            end
            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        req_ready       = 1'b0;
        acct_ctl.mul_en = 1'b0;
        acct_ctl.commit = 1'b0;
        done_go         = 1'b0;
        case (r_state)
            fbpa_pkg::S_IDLE: begin
                req_ready = 1'b1;
            end
            fbpa_pkg::S_MUL: begin
                acct_ctl.mul_en = 1'b1;
            end
            fbpa_pkg::S_DONE: begin
                // Load the result register once it is empty or being drained.
                done_go         = !r_out_valid || o_rsp.ready;
                acct_ctl.commit = done_go && (r_status == fbpa_pkg::ST_OK);
            end
            default: begin
            end
        endcase
    end

    assign in_fire         = i_req.valid && req_ready;
    assign i_req.ready     = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Decide the request against the current pool state.
    // ---------------------------------------------------------------
    always_comb begin
        pool_n    = (r_block_count > fbpa_pkg::COUNT_W'(POOL_CAP))
                  ? fbpa_pkg::COUNT_W'(POOL_CAP) : r_block_count;
        size_ok   = ({{(fbpa_pkg::REQ_W - fbpa_pkg::SIZE_W){1'b0}}, r_block_size}
                     == i_req.request_size);
        can_pop   = (r_depth != '0);
        can_fresh = (r_fresh < pool_n);
        free_bad  = ({1'b0, i_req.freed_block} >= pool_n) || (r_live == '0)
                 || (32'(r_depth) >= 32'(MAX_BLOCKS));

        n_status = fbpa_pkg::ST_OK;
        n_grant  = '0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_fresh = 1'b0;
        if (i_req.operation == fbpa_pkg::OP_ALLOC) begin
            if (!size_ok) begin
                n_status = fbpa_pkg::ST_SIZE;
            end else if (can_pop) begin
                do_pop = 1'b1;
            end else if (can_fresh) begin
                do_fresh = 1'b1;
                n_grant  = r_fresh[fbpa_pkg::IDX_W-1:0];
            end else begin
                n_status = fbpa_pkg::ST_EMPTY;
            end
        end else begin
            if (free_bad) begin
                n_status = fbpa_pkg::ST_BADFREE;
            end else begin
                do_push = 1'b1;
            end
        end
    end

    assign depth_dec = r_depth - DW'(1);
    assign mem_raddr = depth_dec[AW-1:0];
    assign mem_waddr = r_depth[AW-1:0];

    // Advance the pool counters at acceptance; the accounting commits later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_fresh <= '0;
            r_live  <= '0;
        end else if (in_fire) begin
            if (do_pop) begin
                r_depth <= depth_dec;
                r_live  <= r_live + fbpa_pkg::COUNT_W'(1);
            end
            if (do_fresh) begin
                r_fresh <= r_fresh + fbpa_pkg::COUNT_W'(1);
                r_live  <= r_live + fbpa_pkg::COUNT_W'(1);
            end
            if (do_push) begin
                r_depth <= r_depth + DW'(1);
                r_live  <= r_live - fbpa_pkg::COUNT_W'(1);
            end
        end
    end

    // Hold the request's outcome; a stack pop fills in the index from the stack read in the multiply step.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status     <= n_status;
            r_grant      <= n_grant;
            r_from_stack <= do_pop;
        end else if (r_state == fbpa_pkg::S_MUL && r_from_stack) begin
            r_grant <= mem_rdata;
        end
    end

    fbpa_stack_mem #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (in_fire && do_push),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.freed_block),
        .i_re    (in_fire && do_pop),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fbpa_acct u_acct (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (acct_ctl),
        .i_live       (r_live),
        .i_block_size (r_block_size),
        .o_view       (acct_view)
    );

    // ---------------------------------------------------------------
    // Result register: drop valid when taken, load on completion.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_go) begin
            r_out_status     <= r_status;
            r_out_index      <= (r_status == fbpa_pkg::ST_OK) ? r_grant : '0;
            r_out_live       <= r_live;
            r_out_peak       <= acct_view.live_peak;
            r_out_bytes      <= acct_view.byte_total;
            r_out_peak_bytes <= acct_view.byte_peak;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.block_index  = r_out_index;
    assign o_rsp.live_blocks  = r_out_live;
    assign o_rsp.peak_blocks  = r_out_peak;
    assign o_rsp.bytes_in_use = r_out_bytes;
    assign o_rsp.peak_bytes   = r_out_peak_bytes;

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    // Every live block came from the fresh range and is not on the stack.
    a_live_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_live) + 32'(r_depth)) == 32'(r_fresh))
        else $error("live count out of balance with stack depth and fresh index");

    a_fresh_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fresh) <= 32'(POOL_CAP))
        else $error("fresh index ran past the pool capacity");

    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == fbpa_pkg::S_MUL) && !i_req.ready)
        else $error("accepted request did not enter the multiply step");

endmodule

// ===== tb/fbpa_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard class of the allocator bench: predicts each result word and checks it.
package fbpa_tb_pkg;
    import fbpa_pkg::*;

    localparam longint unsigned BYTE_CAP = (64'd1 << BYTE_W) - 1;
    localparam int MISMATCH_SHOWN = 10;

    typedef struct packed {
        t_op                op;
        logic [REQ_W-1:0]   request_size;
        logic [IDX_W-1:0]   freed_block;
    } t_req_word;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   block_index;
        logic [COUNT_W-1:0] live_blocks;
        logic [COUNT_W-1:0] peak_blocks;
        logic [BYTE_W-1:0]  bytes_in_use;
        logic [BYTE_W-1:0]  peak_bytes;
    } t_rsp_word;

    class fbpa_scoreboard;
        logic [IDX_W-1:0] freed_stack [INDEX_SPAN];
        int unsigned      stack_depth;
        int unsigned      fresh_next;
        int unsigned      live_count;
        int unsigned      live_peak;
        longint unsigned  byte_total;
        longint unsigned  byte_peak;
        int unsigned      block_size;
        int unsigned      block_count;
        int unsigned      max_blocks;
        t_rsp_word        expected_q [$];
        int unsigned      held_blocks [$];
        int unsigned      status_seen [4];
        int unsigned      mismatches;
        int unsigned      checked;

        function new(int unsigned max_blocks_p = MAX_BLOCKS_DEF);
            max_blocks  = max_blocks_p;
            stack_depth = 0;
            fresh_next  = 0;
            live_count  = 0;
            live_peak   = 0;
            byte_total  = 0;
            byte_peak   = 0;
            block_size  = BLOCK_SIZE_RST;
            block_count = BLOCK_COUNT_RST;
            mismatches  = 0;
            checked     = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
            if (idx == CFG_BLOCK_SIZE) block_size = value & 32'h1FFFF;
            else block_count = value & 32'h7FF;
        endfunction

        function int unsigned pool_size();
            int unsigned n;
            n = block_count;
            if (n > max_blocks) n = max_blocks;
            if (n > INDEX_SPAN) n = INDEX_SPAN;
            return n;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void update_totals();
            longint unsigned prod;
            prod = longint'(live_count) * longint'(block_size);
            if (prod > BYTE_CAP) prod = BYTE_CAP;
            byte_total = prod;
            if (live_count > live_peak) live_peak = live_count;
            if (byte_total > byte_peak) byte_peak = byte_total;
        endfunction

        function void note_request(t_req_word w);
            t_rsp_word   r;
            int unsigned n;
            int unsigned idx;
            n             = pool_size();
            idx           = w.freed_block;
            r.status      = ST_OK;
            r.block_index = '0;
            if (w.op == OP_ALLOC) begin
                if (w.request_size != block_size) begin
                    r.status = ST_SIZE;
                end else if (stack_depth > 0) begin
                    stack_depth--;
                    r.block_index = freed_stack[stack_depth];
                end else if (fresh_next < n) begin
                    r.block_index = IDX_W'(fresh_next);
                    fresh_next++;
                end else begin
                    r.status = ST_EMPTY;
                end
                if (r.status == ST_OK) begin
                    live_count++;
                    update_totals();
                    held_blocks.push_back(r.block_index);
                end
            end else if (idx >= n || live_count == 0 || stack_depth >= max_blocks) begin
                r.status = ST_BADFREE;
            end else begin
                freed_stack[stack_depth] = w.freed_block;
                stack_depth++;
                live_count--;
                update_totals();
                for (int k = 0; k < held_blocks.size(); k++) begin
                    if (held_blocks[k] == idx) begin
                        held_blocks.delete(k);
                        break;
                    end
                end
            end
            r.live_blocks  = COUNT_W'(live_count);
            r.peak_blocks  = COUNT_W'(live_peak);
            r.bytes_in_use = BYTE_W'(byte_total);
            r.peak_bytes   = BYTE_W'(byte_peak);
            status_seen[r.status]++;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_rsp_word got);
            t_rsp_word want;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN)
                    $display("[%0t] result word with no request outstanding", $time);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.block_index !== want.block_index ||
                got.live_blocks !== want.live_blocks ||
                got.peak_blocks !== want.peak_blocks ||
                got.bytes_in_use !== want.bytes_in_use ||
                got.peak_bytes !== want.peak_bytes) begin
                mismatches++;
                if (mismatches <= MISMATCH_SHOWN) begin
                    $display("[%0t] mismatch: exp st=%0d idx=%0d live=%0d peak=%0d bytes=%0d pbytes=%0d",
                             $time, want.status, want.block_index, want.live_blocks,
                             want.peak_blocks, want.bytes_in_use, want.peak_bytes);
                    $display("            got st=%0d idx=%0d live=%0d peak=%0d bytes=%0d pbytes=%0d",
                             got.status, got.block_index, got.live_blocks,
                             got.peak_blocks, got.bytes_in_use, got.peak_bytes);
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top-level bench of the fixed block pool allocator: clock, reset, drivers and phases.
module tb;
    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;      // settle margin after the last result
    localparam int LONG_HOLD     = 300;    // receiver hold-off under pressure
    localparam int QUIET_LIMIT   = 4000;   // cycles without any handshake

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    fbpa_req_if req_if ();
    fbpa_rsp_if rsp_if ();

    fixed_block_pool_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fbpa_scoreboard sb;

    // Idle knobs shared between the phase sequencer and the two channel drivers.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent   = 0;
    int unsigned phases_run   = 0;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Result side: drive ready each cycle. A pending hold request turns into a
    // long stretch of ready low, counted here, so the block backs up and must
    // stall its request channel while the sender keeps offering words.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Monitor and watchdog: check every accepted result word against the oldest
    // prediction, and end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        t_rsp_word got;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.status       = t_status'(rsp_if.status);
                got.block_index  = rsp_if.block_index;
                got.live_blocks  = rsp_if.live_blocks;
                got.peak_blocks  = rsp_if.peak_blocks;
                got.bytes_in_use = rsp_if.bytes_in_use;
                got.peak_bytes   = rsp_if.peak_bytes;
                sb.check_result(got);
            end
            if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_req_word make_word(t_op op, logic [REQ_W-1:0] size,
                                            logic [IDX_W-1:0] idx);
        t_req_word w;
        w.op           = op;
        w.request_size = size;
        w.freed_block  = idx;
        return w;
    endfunction

    // Build one random word from the current predicted state: allocates mostly
    // carry the right size, frees mostly return a block that is really out.
    function automatic t_req_word random_word(int unsigned alloc_pct);
        t_req_word   w;
        int unsigned pick;
        w.request_size = $urandom;
        w.freed_block  = IDX_W'($urandom_range(INDEX_SPAN - 1));
        pick           = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            w.op = OP_ALLOC;
            if (pick < 85)      w.request_size = sb.block_size;
            else if (pick < 90) w.request_size = sb.block_size + 1;
            else if (pick < 95) w.request_size = sb.block_size - 1;
        end else begin
            w.op = OP_FREE;
            if (pick < 75 && sb.held_blocks.size() > 0)
                w.freed_block = IDX_W'(sb.held_blocks[$urandom_range(sb.held_blocks.size() - 1)]);
            else if (pick < 90 && sb.pool_size() > 0)
                w.freed_block = IDX_W'($urandom_range(sb.pool_size() - 1));
        end
        return w;
    endfunction

    // Offer one request word, with random idle cycles ahead of it, and hold it
    // until the block takes it. Returns in the cycle of the handshake.
    task automatic send_word(input t_req_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= w.op;
        req_if.request_size <= w.request_size;
        req_if.freed_block  <= w.freed_block;
        forever begin
            @(posedge i_clk);
            if (req_if.valid && req_if.ready) break;
        end
        sb.note_request(w);
        words_sent++;
    endtask

    // Drop valid, wait for every predicted word to come back, then let the
    // pipeline settle before anything else changes.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic apply_config(input int unsigned size, input int unsigned count);
        drain();
        write_config(CFG_BLOCK_SIZE, size);
        write_config(CFG_BLOCK_COUNT, count);
    endtask

    task automatic run_phase(input int unsigned size, input int unsigned count,
                             input int unsigned words, input int unsigned alloc_pct,
                             input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit pressure);
        apply_config(size, count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (pressure) hold_request = 1'b1;
        repeat (words) send_word(random_word(alloc_pct));
        phases_run++;
    endtask

    initial begin
        sb = new();
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= CFG_BLOCK_SIZE;
        i_cfg_data          <= '0;
        req_if.valid        <= 1'b0;
        req_if.operation    <= OP_ALLOC;
        req_if.request_size <= '0;
        req_if.freed_block  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings (64-byte blocks, full pool).
        send_word(make_word(OP_FREE,  64, 10'd5));          // nothing live: bad free
        send_word(make_word(OP_ALLOC, 64, 10'd0));          // first fresh block
        send_word(make_word(OP_ALLOC, 63, 10'd0));          // size one short
        send_word(make_word(OP_ALLOC, 0, 10'd0));
        send_word(make_word(OP_ALLOC, 32'hFFFF_FFFF, 10'h3FF));
        send_word(make_word(OP_ALLOC, 64, 10'd0));
        send_word(make_word(OP_FREE,  32'hFFFF_FFFF, 10'd1));
        send_word(make_word(OP_ALLOC, 64, 10'd0));          // reuse the freed block
        send_word(make_word(OP_FREE,  0, 10'd1023));        // never handed out, still taken
        send_word(make_word(OP_FREE,  0, 10'd0));
        send_word(make_word(OP_ALLOC, 64, 10'd0));          // last in, first out
        send_word(make_word(OP_ALLOC, 64, 10'd0));
        send_word(make_word(OP_FREE,  0, 10'd1023));

        // Smallest settings: pool shrunk below the blocks already handed out.
        apply_config(1, 1);
        send_word(make_word(OP_FREE,  0, 10'd1));           // beyond the pool
        send_word(make_word(OP_FREE,  0, 10'd0));
        send_word(make_word(OP_ALLOC, 1, 10'd0));
        send_word(make_word(OP_ALLOC, 1, 10'd0));           // stacked index past pool end
        send_word(make_word(OP_ALLOC, 1, 10'd0));           // empty pool
        send_word(make_word(OP_ALLOC, 2, 10'd0));           // size check wins over empty
        send_word(make_word(OP_FREE,  0, 10'd0));           // block 0 is live again: accepted

        // Block size 65536 with the full pool.
        apply_config(65536, 1024);
        send_word(make_word(OP_ALLOC, 65536, 10'd0));
        send_word(make_word(OP_ALLOC, 65535, 10'd0));
        send_word(make_word(OP_ALLOC, 17'h1_0000 | 32'h8000_0000, 10'd0));
        send_word(make_word(OP_FREE,  0, 10'd2));

        // Random phases: idle pattern, settings and operation mix vary per phase.
        run_phase(64, 1024, 250, 70, 0, 0, 1'b0);
        run_phase(1, 16, 200, 50, 55, 0, 1'b0);
        run_phase(65536, 1024, 300, 65, 0, 55, 1'b1);
        run_phase($urandom_range(65536, 1), $urandom_range(1024, 1), 300, 55, 38, 38, 1'b0);
        run_phase(4096, 1, 150, 50, 38, 38, 1'b0);
        run_phase($urandom_range(65536, 1), $urandom_range(1024, 1), 200, 80, 0, 0, 1'b0);

        drain();
        $display("Run covered %0d request words in %0d random phases plus directed cases",
                 words_sent, phases_run);
        $display("Outcomes: %0d granted/freed, %0d size, %0d empty, %0d bad free; peak %0d blocks",
                 sb.status_seen[ST_OK], sb.status_seen[ST_SIZE], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_BADFREE], sb.live_peak);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_req_if.sv
rtl/core/fbpa_rsp_if.sv
rtl/core/fbpa_stack_mem.sv
rtl/core/fbpa_acct.sv
rtl/core/fixed_block_pool_allocator_unit.sv
tb/fbpa_tb_pkg.sv
tb/tb.sv
